/* rtl/aes_pkg.sv */
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, register indexes, S-box tables and round functions of the
// AES block cipher core.
// ----------------------------------------------------------------------------
package aes_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

  // Opcodes carried on tuser
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic blk_load;   // capture input block
    logic rnd_init;   // initial round key add
    logic rnd_step;   // one full round
    logic rnd_last;   // round without column mixing
    logic dec;        // inverse direction
    logic res_load;   // move state to output register
    logic exp_start;  // load key, reset round constant
    logic exp_step;   // generate one schedule word
    logic exp_key;    // word comes straight from the key
    logic wr_inv;     // write data is a copied encrypt row
    logic inv_mix;    // apply InvMixColumns to the copied row
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3, all;
    a0  = w[31:24];
    a1  = w[23:16];
    a2  = w[15:8];
    a3  = w[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ all ^ xt(a0 ^ a1), a1 ^ all ^ xt(a1 ^ a2),
            a2 ^ all ^ xt(a2 ^ a3), a3 ^ all ^ xt(a3 ^ a0)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int k = 0; k < 4; k++) begin
      a[k]   = w[31 - 8*k -: 8];
      x2     = xt(a[k]);
      x4     = xt(x2);
      x8     = xt(x4);
      m9[k]  = x8 ^ a[k];
      m11[k] = x8 ^ x2 ^ a[k];
      m13[k] = x8 ^ x4 ^ a[k];
      m14[k] = x8 ^ x4 ^ x2;
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [127:0] inv_mix_row(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32*c -: 32] = inv_mix_col(s[127 - 32*c -: 32]);
    end
    return t;
  endfunction

  // Byte substitution and row shift; byte 4c+r is row r of column c
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   v;
    logic [1:0]   f;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        f = inv ? 2'(c - r) : 2'(c + r);
        v = s[127 - 8*(4*int'(f) + r) -: 8];
        t[127 - 8*(4*c + r) -: 8] = inv ? INV_SBOX[v] : SBOX[v];
      end
    end
    return t;
  endfunction

  // One cipher round without the key add
  function automatic logic [127:0] round_core(input logic [127:0] s, input logic inv,
                                              input logic last);
    logic [127:0] t, m;
    t = sub_shift(s, inv);
    for (int c = 0; c < 4; c++) begin
      m[127 - 32*c -: 32] = inv ? inv_mix_col(t[127 - 32*c -: 32])
                                : mix_col(t[127 - 32*c -: 32]);
    end
    return last ? t : m;
  endfunction

endpackage

/* rtl/aes_ram.sv */
// ----------------------------------------------------------------------------
// aes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/aes_ctrl.sv */
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer: key expansion, decrypt schedule copy, round counting and the
// output handshake. Drives the schedule RAM addresses.
// ----------------------------------------------------------------------------
module aes_ctrl
  import aes_pkg::*;
#(
  parameter int SCHEDULE_WORDS = 60
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [1:0]                            cfg_size,
  input  logic                                  s_tvalid,
  input  logic                                  s_tuser,
  output logic                                  s_tready,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output dp_cmd_t                               cmd,
  output logic [3:0]                            nk,
  output logic                                  ram_we,
  output logic [$clog2(2*(SCHEDULE_WORDS/4))-1:0] ram_waddr,
  output logic [$clog2(2*(SCHEDULE_WORDS/4))-1:0] ram_raddr
);

  localparam int ROWS = SCHEDULE_WORDS / 4;
  localparam int AW   = $clog2(2 * ROWS);
  localparam int WCW  = $clog2(SCHEDULE_WORDS);
  localparam int RCW  = $clog2(ROWS + 1);

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_INVERT, S_ROUND, S_HOLD} state_t;

  state_t         state;
  logic           stale;
  logic [1:0]     key_size;
  logic [WCW-1:0] cnt_w;
  logic [RCW-1:0] cnt_r;
  logic           dec_q;
  logic [3:0]     rounds;
  logic [WCW-1:0] last_word;
  logic           cfg_hit;
  logic           accept;

  // Key length in words, reduced until the schedule fits the store
  function automatic logic [3:0] eff_nk(input logic [1:0] ks);
    logic [3:0] n;
    n = (ks >= 2'd2) ? 4'd8 : ((ks == 2'd1) ? 4'd6 : 4'd4);
    if (n == 4'd8 && SCHEDULE_WORDS < 60) n = 4'd6;
    if (n == 4'd6 && SCHEDULE_WORDS < 52) n = 4'd4;
    return n;
  endfunction

  assign rounds    = nk + 4'd6;
  assign last_word = WCW'((32'(nk) + 32'd7) * 32'd4 - 32'd1);
  assign cfg_hit   = cfg_we && (cfg_index <= CFG_KEY_WORD_3);
  assign s_tready  = (state == S_IDLE) && !stale;
  assign accept    = s_tvalid && s_tready;

  // Decode commands and RAM addresses
  always_comb begin
    cmd       = '0;
    cmd.dec   = dec_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (stale) begin
          cmd.exp_start = 1'b1;
        end else if (accept) begin
          cmd.blk_load = 1'b1;
          ram_raddr    = (s_tuser == OP_DECRYPT) ? AW'(ROWS) : '0;
        end
      end
      S_EXPAND: begin
        cmd.exp_step = 1'b1;
        cmd.exp_key  = 32'(cnt_w) < 32'(nk);
        ram_we       = (cnt_w[1:0] == 2'b11);
        ram_waddr    = AW'(cnt_w >> 2);
      end
      S_INVERT: begin
        cmd.wr_inv  = 1'b1;
        cmd.inv_mix = (cnt_r != RCW'(1)) && (32'(cnt_r) != 32'(rounds) + 32'd1);
        if (32'(cnt_r) <= 32'(rounds)) begin
          ram_raddr = AW'(32'(rounds) - 32'(cnt_r));
        end
        ram_we      = (cnt_r != '0);
        ram_waddr   = AW'(32'(ROWS) + 32'(cnt_r) - 32'd1);
      end
      S_ROUND: begin
        cmd.rnd_init = (cnt_r == '0);
        cmd.rnd_step = (cnt_r != '0);
        cmd.rnd_last = (32'(cnt_r) == 32'(rounds));
        if (32'(cnt_r) < 32'(rounds)) begin
          ram_raddr = AW'((dec_q ? 32'(ROWS) : 32'd0) + 32'(cnt_r) + 32'd1);
        end
      end
      S_HOLD: begin
        cmd.res_load = !m_tvalid || m_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State, counters, config and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      stale    <= 1'b1;
      key_size <= '0;
      cnt_w    <= '0;
      cnt_r    <= '0;
      nk       <= 4'd4;
      dec_q    <= OP_ENCRYPT;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_KEY_SIZE) begin
        key_size <= cfg_size;
      end
      if (cfg_hit) begin
        stale <= 1'b1;
      end else if (state == S_IDLE && stale) begin
        stale <= 1'b0;
      end
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (stale) begin
            state <= S_EXPAND;
            nk    <= eff_nk(key_size);
            cnt_w <= '0;
          end else if (accept) begin
            state <= S_ROUND;
            cnt_r <= '0;
            dec_q <= s_tuser;
          end
        end
        S_EXPAND: begin
          cnt_w <= cnt_w + 1'b1;
          if (cnt_w == last_word) begin
            state <= S_INVERT;
            cnt_r <= '0;
          end
        end
        S_INVERT: begin
          if (32'(cnt_r) == 32'(rounds) + 32'd1) begin
            state <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ROUND: begin
          if (32'(cnt_r) == 32'(rounds)) begin
            state <= S_HOLD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_HOLD: begin
          if (cmd.res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_ROUND)
    else $error("accepted block did not start the round sequence");

  a_cfg_marks_stale: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> stale)
    else $error("configuration write did not mark the schedule stale");

  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND || state == S_HOLD) |-> !ram_we)
    else $error("schedule written while a block is in flight");

  a_result_after_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_HOLD)
    else $error("result appeared outside the hold state");

endmodule

/* rtl/aes_dp.sv */
// ----------------------------------------------------------------------------
// aes_dp
// Datapath: key registers, word-serial key expansion, schedule copy with
// InvMixColumns, the shared round unit and the output register.
// ----------------------------------------------------------------------------
module aes_dp
  import aes_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic [127:0]  s_tdata,
  input  dp_cmd_t       cmd,
  input  logic [3:0]    nk,
  input  logic [127:0]  ram_rdata,
  output logic [127:0]  ram_wdata,
  output logic [127:0]  m_tdata
);

  logic [63:0]  key_w [4];
  logic [255:0] keysr;
  logic [31:0]  win [8];
  logic [95:0]  rowbuf;
  logic [2:0]   q;
  logic [7:0]   rcon;
  logic [127:0] st;
  logic [127:0] res;
  logic [31:0]  w1, wnk, t, w_new;

  // Hold key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) key_w[k] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_WORD_0: key_w[0] <= cfg_data;
        CFG_KEY_WORD_1: key_w[1] <= cfg_data;
        CFG_KEY_WORD_2: key_w[2] <= cfg_data;
        CFG_KEY_WORD_3: key_w[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next schedule word from w[i-1] and w[i-nk]
  assign w1  = win[0];
  assign wnk = win[3'(nk - 4'd1)];
  always_comb begin
    if (q == 3'd0) begin
      t = sub_word({w1[23:0], w1[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && q == 3'd4) begin
      t = sub_word(w1);
    end else begin
      t = w1;
    end
    w_new = cmd.exp_key ? keysr[255:224] : (wnk ^ t);
  end

  assign ram_wdata = cmd.wr_inv ? (cmd.inv_mix ? inv_mix_row(ram_rdata) : ram_rdata)
                                : {rowbuf, w_new};

  // Advance expansion window, counters and row buffer
  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      keysr <= {key_w[0], key_w[1], key_w[2], key_w[3]};
      q     <= '0;
      rcon  <= 8'h01;
    end else if (cmd.exp_step) begin
      keysr  <= {keysr[223:0], 32'h0};
      rowbuf <= {rowbuf[63:0], w_new};
      win[0] <= w_new;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
      q <= (q == 3'(nk - 4'd1)) ? 3'd0 : q + 3'd1;
      if (!cmd.exp_key && q == 3'd0) begin
        rcon <= xt(rcon);
      end
    end
  end

  // Cipher state and output register
  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      st <= {s_tdata[63:0], s_tdata[127:64]};
    end else if (cmd.rnd_init) begin
      st <= st ^ ram_rdata;
    end else if (cmd.rnd_step) begin
      st <= round_core(st, cmd.dec, cmd.rnd_last) ^ ram_rdata;
    end
    if (cmd.res_load) begin
      res <= st;
    end
  end

  assign m_tdata = {res[63:0], res[127:64]};

endmodule

/* rtl/aes_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// aes_block_cipher_core
// AES-128/192/256 block cipher with on-chip key schedule expansion.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_size and key words on the cfg port (cfg_index 0..4) while idle.
//   After any write to cfg_index 0..4 or a reset the core expands the key:
//   one schedule word per cycle, then one decrypt row per cycle; s_tready
//   stays low meanwhile.
//   Slave channel: s_tuser is the opcode (0 encrypt, 1 decrypt), s_tdata the
//   block. A transaction occurs when tvalid and tready are both high.
//   Each block uses one round unit, one round per cycle from the schedule
//   RAM: the result lands in the output register from the hold state after
//   the last round, and the next block is accepted only once the core is
//   back in idle, so a block is never taken while another is in flight.
//   The output register holds the result until m_tready; a stalled receiver
//   holds the core after its current block finishes.
//   Reset clears the key to zero, drops any pending result and re-expands.
// ----------------------------------------------------------------------------
module aes_block_cipher_core
  import aes_pkg::*;
#(
  parameter int SCHEDULE_WORDS = 60
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
  input  logic [0:0]   s_tuser,   // opcode [0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // result_high [63:0], result_low [127:64]
);

  localparam int ROWS = SCHEDULE_WORDS / 4;
  localparam int AW   = $clog2(2 * ROWS);

  dp_cmd_t        cmd;
  logic [3:0]     nk;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [127:0]   ram_wdata, ram_rdata;

  aes_ctrl #(.SCHEDULE_WORDS(SCHEDULE_WORDS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_size  (cfg_data[1:0]),
    .s_tvalid  (s_tvalid),
    .s_tuser   (s_tuser[0]),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .nk        (nk),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr)
  );

  aes_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .nk        (nk),
    .ram_rdata (ram_rdata),
    .ram_wdata (ram_wdata),
    .m_tdata   (m_tdata)
  );

  // Encrypt rows at the bottom, decrypt rows from ROWS up
  aes_ram #(.WIDTH(128), .DEPTH(2 * ROWS)) u_sched (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* tb/sv/aes_block_cipher_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_core_tb
// Self-checking bench for the AES block cipher core. A queue-fed driver
// streams blocks under random gaps and a monitor stalls the output at random.
// Every accepted block is run through an independent AES model, covering
// key expansion and the equivalent inverse schedule. Each result is compared
// with the oldest prediction. Keys and key sizes change between phases.
// ----------------------------------------------------------------------------
module aes_block_cipher_core_tb;
  import aes_pkg::*;

  // Indexes past the register map; writes to them must be ignored
  localparam logic [2:0] CFG_SPARE     = 3'd5;
  localparam logic [2:0] CFG_TOP_SPARE = 3'd7;

  typedef struct {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // block_high [63:0], block_low [127:64]
  logic [0:0]   s_tuser = '0;   // opcode [0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // result_high [63:0], result_low [127:64]

  aes_block_cipher_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_t      pending_blocks[$];
  cipher_out_t expected_blocks[$];
  int          fail_count = 0;
  int          results_seen = 0;
  int          phases_run = 0;
  logic        in_taken = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  // Model copy of the key registers and schedules
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  inv_sbox [256];
  logic [1:0]  key_len_sel;
  logic [63:0] key_reg [4];
  logic [31:0] enc_keys [60];
  logic [31:0] dec_keys [60];
  bit          keys_fresh;
  int          round_total;

  function automatic logic [7:0] gf_x2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = gf_x2(a);
    end
    return acc;
  endfunction

  // Build S-boxes from the field inverse and the affine map
  task automatic build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_prod(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      inv_sbox[s] = 8'(x);
    end
  endtask

  function automatic logic [31:0] unmix_word(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = w;
    return {gf_prod(a0, 8'd14) ^ gf_prod(a1, 8'd11) ^ gf_prod(a2, 8'd13) ^ gf_prod(a3, 8'd9),
            gf_prod(a0, 8'd9) ^ gf_prod(a1, 8'd14) ^ gf_prod(a2, 8'd11) ^ gf_prod(a3, 8'd13),
            gf_prod(a0, 8'd13) ^ gf_prod(a1, 8'd9) ^ gf_prod(a2, 8'd14) ^ gf_prod(a3, 8'd11),
            gf_prod(a0, 8'd11) ^ gf_prod(a1, 8'd13) ^ gf_prod(a2, 8'd9) ^ gf_prod(a3, 8'd14)};
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  // Expand the key; size three saturates to 256 bits
  task automatic expand_schedule();
    int nk, words;
    logic [31:0] t, x;
    logic [7:0] rc;
    nk = 4 + 2 * ((key_len_sel > 2'd2) ? 2 : int'(key_len_sel));
    words = 4 * (nk + 7);
    round_total = nk + 6;
    for (int i = 0; i < nk; i++)
      enc_keys[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
    for (int i = nk; i < words; i++) begin
      t = enc_keys[i-1];
      if (i % nk == 0) begin
        rc = 8'h01;
        for (int j = 1; j < i / nk; j++) rc = gf_x2(rc);
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
      end else if (nk == 8 && i % nk == 4) begin
        t = subst_word(t);
      end
      enc_keys[i] = enc_keys[i-nk] ^ t;
    end
    for (int i = 0; i < words; i += 4)
      for (int j = 0; j < 4; j++) begin
        x = enc_keys[words - (i + 4) + j];
        if (i > 0 && i + 4 < words) x = unmix_word(x);
        dec_keys[i+j] = x;
      end
    keys_fresh = 1'b1;
  endtask

  task automatic add_round_key(inout logic [7:0] b [16], input int base, input bit dec);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = dec ? dec_keys[base+c] : enc_keys[base+c];
      for (int r = 0; r < 4; r++) b[4*c+r] ^= w[31-8*r -: 8];
    end
  endtask

  task automatic sub_and_shift(inout logic [7:0] b [16], input bit dec);
    logic [7:0] t [16];
    int from;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        from = dec ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[4*c+r] = dec ? inv_sbox[b[4*from+r]] : fwd_sbox[b[4*from+r]];
      end
    b = t;
  endtask

  task automatic mix_all(inout logic [7:0] b [16], input bit dec);
    logic [7:0] a0, a1, a2, a3, all;
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
      if (dec) begin
        w = unmix_word({a0, a1, a2, a3});
      end else begin
        all = a0 ^ a1 ^ a2 ^ a3;
        w = {a0 ^ all ^ gf_x2(a0 ^ a1), a1 ^ all ^ gf_x2(a1 ^ a2),
             a2 ^ all ^ gf_x2(a2 ^ a3), a3 ^ all ^ gf_x2(a3 ^ a0)};
      end
      {b[4*c], b[4*c+1], b[4*c+2], b[4*c+3]} = w;
    end
  endtask

  // Encrypt or decrypt one block with the current key
  task automatic aes_cipher(input block_t blk, output cipher_out_t res);
    logic [7:0] b [16];
    bit dec;
    dec = (blk.op == OP_DECRYPT);
    if (!keys_fresh) expand_schedule();
    for (int k = 0; k < 8; k++) begin
      b[k]   = blk.hi[63-8*k -: 8];
      b[8+k] = blk.lo[63-8*k -: 8];
    end
    add_round_key(b, 0, dec);
    for (int r = 1; r < round_total; r++) begin
      sub_and_shift(b, dec);
      mix_all(b, dec);
      add_round_key(b, 4*r, dec);
    end
    sub_and_shift(b, dec);
    add_round_key(b, 4*round_total, dec);
    for (int k = 0; k < 8; k++) begin
      res.hi[63-8*k -: 8] = b[k];
      res.lo[63-8*k -: 8] = b[8+k];
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s result %0d: got %h want %h", what, results_seen, got, want);
    fail_count++;
  endtask

  // Write one register at the next falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_KEY_SIZE:   key_len_sel = val[1:0];
      CFG_KEY_WORD_0: key_reg[0] = val;
      CFG_KEY_WORD_1: key_reg[1] = val;
      CFG_KEY_WORD_2: key_reg[2] = val;
      CFG_KEY_WORD_3: key_reg[3] = val;
      default: ;
    endcase
    if (idx <= CFG_KEY_WORD_3) keys_fresh = 1'b0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    block_t b;
    b.op = op; b.hi = hi; b.lo = lo;
    pending_blocks.push_back(b);
  endtask

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return 64'h1 << $urandom_range(0, 63);
    return {$urandom(), $urandom()};
  endfunction

  task automatic wait_idle();
    wait (pending_blocks.size() == 0 && expected_blocks.size() == 0 && !s_tvalid);
    repeat (30) @(posedge clk);
  endtask

  // Driver: present blocks, hold until accepted, then idle for a random gap
  always @(negedge clk) begin
    block_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !in_taken)) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_blocks.size() > 0) begin
        b = pending_blocks.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {b.lo, b.hi};
        s_tuser <= b.op;
        send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Predict on each input transaction, check on each output transaction
  always @(posedge clk) begin
    block_t blk;
    cipher_out_t want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      blk.op = s_tuser[0]; blk.hi = s_tdata[63:0]; blk.lo = s_tdata[127:64];
      aes_cipher(blk, want);
      expected_blocks.push_back(want);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected", m_tdata[63:0], '0);
      end else begin
        want = expected_blocks.pop_front();
        if (m_tdata[63:0] !== want.hi) report_mismatch("result_high", m_tdata[63:0], want.hi);
        if (m_tdata[127:64] !== want.lo) report_mismatch("result_low", m_tdata[127:64], want.lo);
      end
      results_seen++;
    end
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still expected", expected_blocks.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus phases
  initial begin
    build_sboxes();
    key_len_sel = 2'd0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    keys_fresh = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset key of all zeros, extreme blocks both ways
    queue_block(OP_ENCRYPT, '0, '0);
    queue_block(OP_DECRYPT, '0, '0);
    queue_block(OP_ENCRYPT, '1, '1);
    queue_block(OP_DECRYPT, '1, '1);
    wait_idle();

    // Known 128-bit key with its standard plaintext
    write_reg(CFG_KEY_WORD_0, 64'h0001020304050607);
    write_reg(CFG_KEY_WORD_1, 64'h08090a0b0c0d0e0f);
    queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    wait_idle();

    // 192-bit and 256-bit keys, then size three saturating to 256
    write_reg(CFG_KEY_WORD_2, 64'h1011121314151617);
    write_reg(CFG_KEY_SIZE, 64'd1);
    queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(OP_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    wait_idle();
    write_reg(CFG_KEY_WORD_3, 64'h18191a1b1c1d1e1f);
    write_reg(CFG_KEY_SIZE, 64'd2);
    queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    wait_idle();
    write_reg(CFG_KEY_SIZE, {$urandom(), $urandom()} | 64'd3);
    write_reg(CFG_SPARE, '1);
    queue_block(OP_ENCRYPT, '0, '1);
    queue_block(OP_DECRYPT, '1, '0);
    wait_idle();
    write_reg(CFG_TOP_SPARE, {$urandom(), $urandom()});
    queue_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    wait_idle();

    // Random phases: fresh keys and sizes, extremes included
    for (int p = 0; p < 12; p++) begin
      no_idle = (p % 4 == 3);
      write_reg(CFG_KEY_SIZE, {$urandom(), 30'($urandom()), 2'(p % 4)});
      for (int w = 0; w < 4; w++) begin
        if (p == 4)      write_reg(3'(CFG_KEY_WORD_0 + w), '1);
        else if (p == 5) write_reg(3'(CFG_KEY_WORD_0 + w), '0);
        else             write_reg(3'(CFG_KEY_WORD_0 + w), rand_word());
      end
      for (int n = 0; n < 100; n++)
        queue_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, rand_word(), rand_word());
      wait_idle();
      phases_run++;
    end
    no_idle = 1'b0;

    wait (expected_blocks.size() == 0);
    repeat (40) @(posedge clk);
    $display("Covered %0d results over %0d random key phases, all key sizes, both directions",
             results_seen, phases_run);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
